// ===== src/cumulative_skip_mlp_forward_assert.svh =====
// Assertion macros for the skip-connection MLP block.
`ifndef CUMULATIVE_SKIP_MLP_FORWARD_ASSERT_SVH
`define CUMULATIVE_SKIP_MLP_FORWARD_ASSERT_SVH
`ifndef SYNTHESIS
`define CSM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CSM_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/csmlp_pkg.sv =====
// Package: types and constants of the skip-connection MLP block.
`timescale 1ns / 1ps
package csmlp_pkg;
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_GENE   = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  localparam logic [2:0] REG_LAYERS = 3'd0;
  localparam logic [2:0] REG_W0     = 3'd1;
  localparam logic [2:0] REG_W3     = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_BIAS_RD, ST_BIAS_WR, ST_NSTART, ST_BIAS_WAIT,
    ST_MAC, ST_MAC_DRAIN, ST_FINISH, ST_EMIT
  } csm_state_t;

  typedef struct packed {
    logic busy;
    logic emit;
  } csm_status_t;
endpackage

// ===== src/cumulative_skip_mlp_forward.sv =====
// Top level: skip-connection MLP with weight, bias and activation memories.
// After reset and on every clear item the block sweeps the weight memory one entry
// per cycle ((MAX_LAYERS-1)*MAX_WIDTH*MAX_LAYERS*MAX_WIDTH entries, 3072 at default),
// zeroing the biases along the way, with the input stalled. A gene writes its weight
// when accepted, then reads and adds its bias; a sample without last only stores its
// activation. A run computes each neuron of layers one and up with one multiplier
// walking every earlier neuron, one weight read per cycle; empty source layers after
// the first non-empty one still take a walk step, and each output neuron goes to the
// output register, which waits while the receiver stalls. The weight memory port sets the rate.
`timescale 1ns / 1ps
module cumulative_skip_mlp_forward #(
  parameter int MAX_LAYERS = 4,
  parameter int MAX_WIDTH  = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_mode,
  input  logic [1:0]                   in_target_layer,
  input  logic [3:0]                   in_target_neuron,
  input  logic [1:0]                   in_source_layer,
  input  logic [3:0]                   in_source_neuron,
  input  logic signed [VALUE_BITS-1:0] in_weight,
  input  logic signed [VALUE_BITS-1:0] in_bias,
  input  logic signed [VALUE_BITS-1:0] in_sample,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] out_activation,
  output logic [3:0]                   out_neuron_index,
  output logic                         out_final_res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [4:0]                   cfg_data
);
  import csmlp_pkg::*;
  `include "cumulative_skip_mlp_forward_assert.svh"

  localparam int LB    = (MAX_LAYERS > 2) ? $clog2(MAX_LAYERS) : 1;
  localparam int NB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SLOTS = (MAX_LAYERS - 1) * MAX_WIDTH;
  localparam int ROWB  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int COLS  = MAX_LAYERS * MAX_WIDTH;
  localparam int COLB  = $clog2(COLS);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int WADR  = ROWB + COLB;
  localparam int CLRN  = SLOTS * COLS;
  localparam int CLRB  = $clog2(CLRN + 1);
  localparam int ACCB  = 2 * VALUE_BITS + 8;
  localparam logic signed [VALUE_BITS:0] VMAXE = (VALUE_BITS+1)'((64'd1 << (VALUE_BITS-1)) - 1);
  localparam logic signed [VALUE_BITS:0] VMINE = -VMAXE - (VALUE_BITS+1)'(1);

  // config
  logic [2:0] lc_reg_r;
  logic [4:0] wreg_r [4];
  logic [LB:0] lc;
  logic [WB-1:0] ew [MAX_LAYERS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_reg_r <= 3'd2;
      for (int i = 0; i < 4; i++) wreg_r[i] <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LAYERS) lc_reg_r <= cfg_data[2:0];
      else if (cfg_index >= REG_W0 && cfg_index <= REG_W3)
        wreg_r[cfg_index[1:0] - 2'd1] <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  always_comb begin
    if (lc_reg_r < 3'd2) lc = (LB+1)'(2);
    else if (32'(lc_reg_r) > MAX_LAYERS) lc = (LB+1)'(MAX_LAYERS);
    else lc = (LB+1)'(lc_reg_r);
    for (int l = 0; l < MAX_LAYERS; l++) begin
      if (l >= 4) ew[l] = '0;
      else if (32'(wreg_r[l]) > MAX_WIDTH) ew[l] = WB'(MAX_WIDTH);
      else ew[l] = WB'(wreg_r[l]);
    end
  end

  // memories
  logic signed [VALUE_BITS-1:0] wmem [CLRN];
  logic signed [VALUE_BITS-1:0] bmem [SLOTS];
  logic signed [VALUE_BITS-1:0] amem [COLS];
  logic              w_we, b_we, a_we;
  logic [WADR-1:0]   w_wa, w_ra;
  logic [ROWB-1:0]   b_a;
  logic [COLB-1:0]   a_wa, a_ra;
  logic signed [VALUE_BITS-1:0] w_wd, b_wd, a_wd, w_rd_r, b_rd_r, a_rd_r;

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_wa] <= w_wd;
    w_rd_r <= wmem[w_ra];
    if (b_we) bmem[b_a] <= b_wd;
    b_rd_r <= bmem[b_a];
    if (a_we) amem[a_wa] <= a_wd;
    a_rd_r <= amem[a_ra];
  end

  // control
  csm_state_t st_r, st_nxt;
  logic [CLRB-1:0] clr_r, clr_nxt;
  logic [LB-1:0] L_r, L_nxt, sl_r, sl_nxt;
  logic [NB-1:0] sn_r, sn_nxt;
  logic [WB-1:0] n_r, n_nxt;
  logic [ROWB-1:0] grow_r, grow_nxt;
  logic signed [VALUE_BITS-1:0] gbias_r, gbias_nxt;
  logic mac_load, mac_en, mac_en_r, mac_en_d_r;
  logic signed [VALUE_BITS-1:0] mac_res;
  logic signed [VALUE_BITS-1:0] oact_r, oact_nxt;
  logic [3:0] oidx_r, oidx_nxt;
  logic ofin_r, ofin_nxt;
  logic ovld_r, ovld_nxt;
  logic in_acc;
  logic gene_ok, issue_end;
  logic signed [VALUE_BITS:0] bsum;
  logic [ROWB-1:0] cur_row;
  logic [LB:0] L_ext;
  logic [WB-1:0] Lw;
  csm_status_t stat;

  assign in_acc = in_valid && !in_stall;
  assign L_ext  = (LB+1)'(L_r);
  assign Lw     = ew[L_r];
  assign cur_row = ROWB'((32'(L_r) - 1) * MAX_WIDTH + 32'(n_r));
  assign gene_ok = in_target_layer != 2'd0 && 32'(in_target_layer) < 32'(lc)
                && in_source_layer < in_target_layer
                && 32'(in_target_neuron) < 32'(ew[in_target_layer])
                && 32'(in_source_neuron) < 32'(ew[in_source_layer]);
  assign bsum = (VALUE_BITS+1)'(b_rd_r) + (VALUE_BITS+1)'(gbias_r);
  // last source of this neuron is sl == L-1, sn == width-1; empty layers skipped
  assign issue_end = (32'(sn_r) + 1 >= 32'(ew[sl_r])) && (32'(sl_r) + 1 >= 32'(L_r));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_CLEAR) st_nxt = ST_CLEAR;
          else if (in_mode == MODE_GENE && gene_ok) st_nxt = ST_BIAS_RD;
          else if (in_mode == MODE_SAMPLE && in_last) st_nxt = ST_NSTART;
        end
      end
      ST_CLEAR:     if (32'(clr_r) + 1 >= CLRN) st_nxt = ST_IDLE;
      ST_BIAS_RD:   st_nxt = ST_BIAS_WR;
      ST_BIAS_WR:   st_nxt = ST_IDLE;
      ST_NSTART: begin
        if (32'(n_r) >= 32'(Lw)) begin
          if (L_ext + 1 >= lc) st_nxt = ST_IDLE;
          else st_nxt = ST_NSTART;
        end else begin
          st_nxt = ST_BIAS_WAIT;
        end
      end
      ST_BIAS_WAIT: st_nxt = ST_MAC;
      ST_MAC:       if (issue_end) st_nxt = ST_MAC_DRAIN;
      // wait until the last product has reached the accumulator
      ST_MAC_DRAIN: if (!mac_en_r && !mac_en_d_r) st_nxt = ST_FINISH;
      ST_FINISH:    st_nxt = (L_ext + 1 >= lc) ? ST_EMIT : ST_NSTART;
      ST_EMIT:      if (!ovld_r || !out_stall) st_nxt = ST_NSTART;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt = clr_r;
    L_nxt = L_r; n_nxt = n_r; sl_nxt = sl_r; sn_nxt = sn_r;
    grow_nxt = grow_r; gbias_nxt = gbias_r;
    w_we = 1'b0; w_wa = '0; w_wd = '0;
    w_ra = WADR'(32'(cur_row) * COLS + 32'(sl_r) * MAX_WIDTH + 32'(sn_r));
    b_we = 1'b0; b_a = cur_row; b_wd = '0;
    a_we = 1'b0; a_wa = '0; a_wd = in_sample;
    a_ra = COLB'(32'(sl_r) * MAX_WIDTH + 32'(sn_r));
    mac_load = 1'b0; mac_en = 1'b0;
    ovld_nxt = ovld_r; oact_nxt = oact_r; oidx_nxt = oidx_r; ofin_nxt = ofin_r;
    if (ovld_r && !out_stall) ovld_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        clr_nxt = '0;
        L_nxt = LB'(1); n_nxt = '0;
        grow_nxt = ROWB'((32'(in_target_layer) - 1) * MAX_WIDTH + 32'(in_target_neuron));
        gbias_nxt = in_bias;
        b_a = grow_nxt;
        if (in_acc && in_mode == MODE_GENE && gene_ok) begin
          w_we = 1'b1;
          w_wa = WADR'(32'(grow_nxt) * COLS + 32'(in_source_layer) * MAX_WIDTH
                       + 32'(in_source_neuron));
          w_wd = in_weight;
        end
        if (in_acc && in_mode == MODE_SAMPLE && 32'(in_source_neuron) < 32'(ew[0])) begin
          a_we = 1'b1; a_wa = COLB'(in_source_neuron);
        end
      end
      ST_CLEAR: begin
        w_we = 1'b1; w_wa = WADR'(clr_r); w_wd = '0;
        if (32'(clr_r) < SLOTS) begin
          b_we = 1'b1; b_a = ROWB'(clr_r);
        end
        clr_nxt = clr_r + CLRB'(1);
      end
      ST_BIAS_RD: b_a = grow_r;
      ST_BIAS_WR: begin
        b_a = grow_r; b_we = 1'b1;
        if (bsum > VMAXE) b_wd = VMAXE[VALUE_BITS-1:0];
        else if (bsum < VMINE) b_wd = VMINE[VALUE_BITS-1:0];
        else b_wd = bsum[VALUE_BITS-1:0];
      end
      ST_NSTART: begin
        sl_nxt = '0; sn_nxt = '0;
        if (32'(n_r) >= 32'(Lw)) begin
          L_nxt = L_r + LB'(1); n_nxt = '0;
        end
      end
      ST_BIAS_WAIT: begin
        mac_load = 1'b1;
        // skip empty leading source layers
        if (ew[0] == '0) begin
          for (int l = 1; l < MAX_LAYERS; l++)
            if (sl_nxt == '0 && ew[l] != '0) sl_nxt = LB'(l);
        end
      end
      ST_MAC: begin
        mac_en = (32'(sn_r) < 32'(ew[sl_r])) && (sl_r < L_r);
        if (32'(sn_r) + 1 >= 32'(ew[sl_r])) begin
          sn_nxt = '0; sl_nxt = sl_r + LB'(1);
        end else begin
          sn_nxt = sn_r + NB'(1);
        end
      end
      ST_FINISH: begin
        if (L_ext + 1 < lc) begin
          a_we = 1'b1; a_wa = COLB'(32'(L_r) * MAX_WIDTH + 32'(n_r)); a_wd = mac_res;
          n_nxt = n_r + WB'(1);
        end
      end
      ST_EMIT: begin
        if (!ovld_r || !out_stall) begin
          ovld_nxt = 1'b1; oact_nxt = mac_res; oidx_nxt = 4'(n_r);
          ofin_nxt = (32'(n_r) + 1 == 32'(Lw));
          n_nxt = n_r + WB'(1);
        end
      end
      default: ;
    endcase
  end

  // weight/activation read data are registered and arrive together in the cycle after issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= '0;
      ovld_r <= 1'b0; mac_en_r <= 1'b0; mac_en_d_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt;
      ovld_r <= ovld_nxt; mac_en_r <= mac_en; mac_en_d_r <= mac_en_r;
    end
    L_r <= L_nxt; n_r <= n_nxt; sl_r <= sl_nxt; sn_r <= sn_nxt;
    grow_r <= grow_nxt; gbias_r <= gbias_nxt;
    oact_r <= oact_nxt; oidx_r <= oidx_nxt; ofin_r <= ofin_nxt;
  end

  csmlp_mac #(.VALUE_BITS(VALUE_BITS), .ACC_BITS(ACCB)) u_mac (
    .clk(clk), .load(mac_load), .load_bias(b_rd_r),
    .mac_en(mac_en_r), .mul_a(w_rd_r), .mul_b(a_rd_r), .result(mac_res)
  );

  assign stat.busy = st_r != ST_IDLE;
  assign stat.emit = st_r == ST_EMIT;
  assign in_stall = stat.busy;
  assign out_valid = ovld_r;
  assign out_activation = oact_r;
  assign out_neuron_index = oidx_r;
  assign out_final_res = ofin_r;

  `CSM_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, stat.busy, in_stall)
  `CSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_activation))
  `CSM_ASSERT_IMPL(a_emit_only_run, clk, rst_n, $rose(out_valid), $past(stat.emit))
endmodule

// ===== src/csmlp_mac.sv =====
// Multiply-accumulate unit with Q8.8 rounding and saturation.
`timescale 1ns / 1ps
module csmlp_mac #(
  parameter int VALUE_BITS = 16,
  parameter int ACC_BITS   = 40
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic signed [VALUE_BITS-1:0] load_bias,
  input  logic                         mac_en,
  input  logic signed [VALUE_BITS-1:0] mul_a,
  input  logic signed [VALUE_BITS-1:0] mul_b,
  output logic signed [VALUE_BITS-1:0] result
);
  import csmlp_pkg::*;
  localparam int PB = 2 * VALUE_BITS;
  logic signed [PB-1:0] prod_r;
  logic signed [PB-1:0] prod_nxt;
  logic                 pv_r;
  logic signed [ACC_BITS-1:0] acc_r;
  logic signed [ACC_BITS-1:0] acc_nxt;
  logic signed [ACC_BITS-1:0] rnd;
  logic signed [ACC_BITS-9:0] shf;
  localparam logic signed [ACC_BITS-9:0] VMAX = (ACC_BITS-8)'((64'd1 << (VALUE_BITS-1)) - 1);
  localparam logic signed [ACC_BITS-9:0] VMIN = -VMAX - (ACC_BITS-8)'(1);

  assign prod_nxt = mul_a * mul_b;

  always_comb begin
    acc_nxt = acc_r;
    if (load) begin
      acc_nxt = ACC_BITS'(load_bias) <<< 8;
    end else if (pv_r) begin
      acc_nxt = acc_r + ACC_BITS'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    pv_r   <= mac_en;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    rnd = acc_r + ACC_BITS'(128);
    shf = rnd[ACC_BITS-1:8];
    if (shf > VMAX) begin
      result = VMAX[VALUE_BITS-1:0];
    end else if (shf < VMIN) begin
      result = VMIN[VALUE_BITS-1:0];
    end else begin
      result = shf[VALUE_BITS-1:0];
    end
  end
endmodule
